FILE: src/hex_record_data_extractor_assert.svh
// ----------------------------------------------------------------------------
// hex record data extractor assertion macros
// shared property forms for the checker, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef HEX_RECORD_DATA_EXTRACTOR_ASSERT_SVH
`define HEX_RECORD_DATA_EXTRACTOR_ASSERT_SVH

// same-cycle implication
`define HRDE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrde same-cycle check failed");

// next-cycle implication
`define HRDE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrde next-cycle check failed");

`endif

FILE: src/hrde_pkg.sv
// ----------------------------------------------------------------------------
// hrde_pkg
// types, character codes and the hex digit decoder of the record extractor
// ----------------------------------------------------------------------------
package hrde_pkg;

  localparam int unsigned POS_W   = 10;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned INDEX_W = 7;
  localparam int unsigned WORD_W  = 16;

  localparam logic [POS_W-1:0] POS_MAX    = '1;
  localparam logic [POS_W-1:0] POS_COUNT_HI = POS_W'(1);
  localparam logic [POS_W-1:0] POS_COUNT_LO = POS_W'(2);
  localparam logic [POS_W-1:0] DATA_START = POS_W'(9);

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  typedef struct packed {
    logic [7:0] hex_char;
    logic       record_start;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  data_word;
    logic [INDEX_W-1:0] word_index;
    logic               last_word;
    logic               bad_digit;
  } out_item_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } nibble_dec_t;

  // bad digits decode as 15 with the flag set
  function automatic nibble_dec_t decode_nibble(input logic [7:0] c);
    nibble_dec_t d;
    logic [7:0]  diff;
    d    = '{bad: 1'b1, value: 4'hf};
    diff = '0;
    if (c >= CH_0 && c <= CH_9) begin
      diff = c - CH_0;
      d    = '{bad: 1'b0, value: diff[3:0]};
    end else if (c >= CH_UA && c <= CH_UF) begin
      diff = c - CH_UA + 8'd10;
      d    = '{bad: 1'b0, value: diff[3:0]};
    end else if (c >= CH_LA && c <= CH_LF) begin
      diff = c - CH_LA + 8'd10;
      d    = '{bad: 1'b0, value: diff[3:0]};
    end
    return d;
  endfunction

endpackage

FILE: src/hex_record_data_extractor.sv
// ----------------------------------------------------------------------------
// hex_record_data_extractor
// decodes the data field of hex records into byte-swapped 16-bit words
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_item carry one record character per item, with
//   record_start set on the leading character of each record
//   out_valid/out_stall/out_item carry one data word per four data digits,
//   with its index in the record, a last-word mark and a bad-digit flag
// path: a character is held in the input register and its word, if any, is
//   loaded into the result register as the character leaves it, so a word
//   passes through both registers after its final digit is accepted
// throughput: one character per cycle unless a word is held, set by the
//   single decode and counter update between input and result registers
// stalls: while out_stall holds a word, one more character waits in the
//   input register and in_stall rises only once that register is also full
// reset: both registers empty, record state cleared, characters before the
//   first record start are dropped
// ----------------------------------------------------------------------------
module hex_record_data_extractor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrde_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output hrde_pkg::out_item_t out_item
);
  import hrde_pkg::*;

  logic                 in_valid_r, in_valid_nxt;
  in_item_t             in_item_r;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 acc_r, acc_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [11:0]          nib_r, nib_nxt;
  logic [INDEX_W-1:0]   wcnt_r, wcnt_nxt;
  logic                 derr_r, derr_nxt;

  logic                 advance;
  logic                 emit;
  logic [POS_W-1:0]     pos_inc;
  logic [1:0]           digit;
  logic [INDEX_W-1:0]   words;
  nibble_dec_t          dec;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign in_valid_nxt = in_stall ? in_valid_r : in_valid;
  assign pos_inc      = pos_r + POS_W'(1);
  assign digit        = pos_inc[1:0] - DATA_START[1:0];
  assign words        = count_r[COUNT_W-1:1];
  assign dec          = decode_nibble(in_item_r.hex_char);

  always_comb begin
    pos_nxt      = pos_r;
    acc_nxt      = acc_r;
    count_nxt    = count_r;
    nib_nxt      = nib_r;
    wcnt_nxt     = wcnt_r;
    derr_nxt     = derr_r;
    emit         = 1'b0;
    out_item_nxt = out_item_r;
    if (advance) begin
      if (in_item_r.record_start) begin
        pos_nxt   = '0;
        acc_nxt   = (in_item_r.hex_char == CH_COLON);
        count_nxt = '0;
        nib_nxt   = '0;
        wcnt_nxt  = '0;
        derr_nxt  = 1'b0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_inc;
        if (acc_r) begin
          if (pos_inc == POS_COUNT_HI) begin
            count_nxt = {dec.value, 4'h0};
          end else if (pos_inc == POS_COUNT_LO) begin
            count_nxt = count_r | {4'h0, dec.value};
          end else if (pos_inc >= DATA_START && wcnt_r < words) begin
            case (digit)
              2'd0: begin
                nib_nxt  = {8'h00, dec.value};
                derr_nxt = dec.bad;
              end
              2'd1, 2'd2: begin
                nib_nxt  = {nib_r[7:0], dec.value};
                derr_nxt = derr_r | dec.bad;
              end
              2'd3: begin
                emit                    = 1'b1;
                out_item_nxt.data_word  = {nib_r[3:0], dec.value, nib_r[11:4]};
                out_item_nxt.word_index = wcnt_r;
                out_item_nxt.last_word  = ((wcnt_r + INDEX_W'(1)) == words);
                out_item_nxt.bad_digit  = derr_r | dec.bad;
                wcnt_nxt                = wcnt_r + INDEX_W'(1);
                derr_nxt                = 1'b0;
                nib_nxt                 = '0;
              end
              default: begin
                nib_nxt = nib_r;
              end
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      acc_r       <= 1'b0;
      count_r     <= '0;
      nib_r       <= '0;
      wcnt_r      <= '0;
      derr_r      <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      count_r     <= count_nxt;
      nib_r       <= nib_nxt;
      wcnt_r      <= wcnt_nxt;
      derr_r      <= derr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
    if (emit) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

FILE: src/hrde_checker.sv
// ----------------------------------------------------------------------------
// hrde_port_checks
// port-level checks on the hex record data extractor, bound to the top level
// ----------------------------------------------------------------------------
`include "hex_record_data_extractor_assert.svh"

module hrde_port_checks (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input hrde_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input hrde_pkg::out_item_t out_item
);
  import hrde_pkg::*;

  logic in_take;

  assign in_take = in_valid && !in_stall;

  // stalled item stays
  `HRDE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
  // no word right out of reset
  `HRDE_ASSERT_SAME(a_reset_empty, !$past(rst_n), !out_valid)
  // input backs up only behind a held word
  `HRDE_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall)
  // a new word needs a character taken and passed on through the input register
  `HRDE_ASSERT_SAME(a_word_source, out_valid && !$past(out_valid), $past(in_take, 2))

endmodule

bind hex_record_data_extractor hrde_port_checks u_hrde_port_checks (.*);

FILE: sim/hrde_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hrde_checker
// follows every accepted record character, works out the data words that the
// extractor must emit and compares each emitted word with the oldest one due
// ----------------------------------------------------------------------------
module hrde_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  hrde_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  hrde_pkg::out_item_t out_item,
  output int                  err_count,
  output int                  pending
);
  import hrde_pkg::*;

  out_item_t          words_due[$];
  int                 mismatches = 0;
  logic [POS_W-1:0]   rec_pos;
  logic               rec_open;
  logic [COUNT_W-1:0] rec_bytes;
  logic [11:0]        digit_acc;
  logic [INDEX_W-1:0] words_done;
  logic               word_bad;

  assign err_count = mismatches;

  // {bad, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h0f;
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = c - CH_UA + 8'd10;
    end else if (c >= CH_LA && c <= CH_LF) begin
      v = c - CH_LA + 8'd10;
    end else begin
      return 5'h1f;
    end
    return {1'b0, v[3:0]};
  endfunction

  task automatic track_char(input in_item_t it);
    logic [4:0]         dec;
    logic [INDEX_W-1:0] words;
    logic [1:0]         phase;
    out_item_t          w;
    if (it.record_start) begin
      rec_pos    = '0;
      rec_open   = (it.hex_char == CH_COLON);
      rec_bytes  = '0;
      digit_acc  = '0;
      words_done = '0;
      word_bad   = 1'b0;
    end else if (rec_pos != POS_MAX) begin
      rec_pos = rec_pos + 1'b1;
      if (rec_open) begin
        dec   = hex_value(it.hex_char);
        words = rec_bytes[7:1];
        phase = 2'(rec_pos - DATA_START);
        if (rec_pos == POS_COUNT_HI) begin
          rec_bytes = {dec[3:0], 4'h0};
        end else if (rec_pos == POS_COUNT_LO) begin
          rec_bytes[3:0] = dec[3:0];
        end else if (rec_pos >= DATA_START && words_done < words) begin
          case (phase)
            2'd0: begin
              digit_acc = {8'h00, dec[3:0]};
              word_bad  = dec[4];
            end
            2'd1, 2'd2: begin
              digit_acc = {digit_acc[7:0], dec[3:0]};
              word_bad  = word_bad | dec[4];
            end
            default: begin
              // digits d0 d1 d2 d3 give d2d3 high byte, d0d1 low byte
              w.data_word  = {digit_acc[3:0], dec[3:0], digit_acc[11:4]};
              w.word_index = words_done;
              w.last_word  = (words_done + 1'b1 == words);
              w.bad_digit  = word_bad | dec[4];
              words_due.push_back(w);
              words_done = words_done + 1'b1;
              word_bad   = 1'b0;
              digit_acc  = '0;
            end
          endcase
        end
      end
    end
  endtask

  task automatic check_word(input out_item_t got);
    out_item_t want;
    if (words_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected word %h idx %0d last %b bad %b", $realtime,
                 got.data_word, got.word_index, got.last_word, got.bad_digit);
      return;
    end
    want = words_due.pop_front();
    if (got.data_word !== want.data_word || got.word_index !== want.word_index ||
        got.last_word !== want.last_word || got.bad_digit !== want.bad_digit) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: word mismatch exp %h/%0d/%b/%b got %h/%0d/%b/%b", $realtime,
                 want.data_word, want.word_index, want.last_word, want.bad_digit,
                 got.data_word, got.word_index, got.last_word, got.bad_digit);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      words_due.delete();
      rec_pos    = '0;
      rec_open   = 1'b0;
      rec_bytes  = '0;
      digit_acc  = '0;
      words_done = '0;
      word_bad   = 1'b0;
      mismatches = 0;
      pending   <= 0;
    end else begin
      if (out_valid && !out_stall) check_word(out_item);
      if (in_valid && !in_stall) track_char(in_item);
      pending <= words_due.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// feeds hex records to the extractor: a few hand-built records, then random
// well-formed, truncated and garbage records plus a very long one, with
// random gaps and output stalls; the checker does the scoring
// ----------------------------------------------------------------------------
module tb_top;
  import hrde_pkg::*;

  localparam int         QUIET_LIMIT  = 5000;
  localparam int         RANDOM_CHARS = 850;
  localparam logic [7:0] LINE_CR      = 8'h0d;
  localparam logic [7:0] LINE_LF      = 8'h0a;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_stall = 1'b0;
  logic      idle_en   = 1'b1;
  in_item_t  in_item   = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        chars_sent = 0;
  int        quiet_cycles = 0;

  always #2 clk = ~clk;

  hex_record_data_extractor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  hrde_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .err_count(fail_count),
    .pending  (pending)
  );

  always @(posedge clk) begin
    out_stall <= idle_en && ($urandom_range(0, 99) < 33);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic starts);
    while (idle_en && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      in_item  <= in_item_t'(9'($urandom));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{hex_char: ch, record_start: starts};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic starts);
    for (int i = 0; i < s.len(); i++) send_char(s[i], starts && i == 0);
  endtask

  function automatic logic [7:0] hex_ascii(input logic [3:0] v);
    if (v < 4'd10) return CH_0 + v;
    if ($urandom_range(0, 1)) return CH_UA + (v - 4'd10);
    return CH_LA + (v - 4'd10);
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
           (c >= CH_LA && c <= CH_LF));
    return c;
  endfunction

  function automatic logic [7:0] pick_count();
    if ($urandom_range(0, 24) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 20));
  endfunction

  task automatic send_digit(input logic [3:0] v, input int bad_pct);
    if ($urandom_range(0, 99) < bad_pct) send_char(junk_char(), 1'b0);
    else send_char(hex_ascii(v), 1'b0);
  endtask

  // cut < 0 sends the whole record with checksum, otherwise stops after cut digits
  task automatic send_record(input logic [7:0] bytes, input int bad_pct, input int cut);
    int digits;
    send_char(CH_COLON, 1'b1);
    send_digit(bytes[7:4], bad_pct);
    send_digit(bytes[3:0], bad_pct);
    repeat (6) send_digit(4'($urandom_range(0, 15)), 0);
    digits = (cut >= 0) ? cut : 2 * bytes;
    repeat (digits) send_digit(4'($urandom_range(0, 15)), bad_pct);
    if (cut < 0) begin
      repeat (2) send_digit(4'($urandom_range(0, 15)), 0);
      if ($urandom_range(0, 1)) begin
        send_char(LINE_CR, 1'b0);
        send_char(LINE_LF, 1'b0);
      end
    end
  endtask

  initial begin
    logic [7:0] bytes;
    logic [7:0] c;
    int         pick;
    int         bad_pct;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // characters before any record start
    send_text("z5", 1'b0);
    send_text(":04000000", 1'b1);
    send_text("0aF9G1ff", 1'b0);
    // record without a colon, extreme character codes
    send_char(8'hff, 1'b1);
    send_char(8'h00, 1'b0);
    // byte count below two
    send_text(":01000000ab", 1'b1);

    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      idle_en <= !(chars_sent >= 300 && chars_sent < 600);
      pick    = $urandom_range(0, 99);
      bad_pct = ($urandom_range(0, 9) < 3) ? 6 : 0;
      bytes   = pick_count();
      if (pick < 70) begin
        send_record(bytes, bad_pct, -1);
      end else if (pick < 82) begin
        send_record(bytes, bad_pct, $urandom_range(0, 2 * bytes));
      end else if (pick < 92) begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_COLON);
        send_char(c, 1'b1);
        repeat ($urandom_range(0, 12)) send_char(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        // stray characters continue whatever record is open
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) send_char(8'($urandom_range(0, 255)), 1'b0);
          else send_digit(4'($urandom_range(0, 15)), 0);
        end
      end
    end
    idle_en <= 1'b1;

    // word indices 0 to 126, then the position counter saturates
    send_record(8'hff, 0, 1030);
    send_record(8'h06, 0, -1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/hrde_pkg.sv
src/hex_record_data_extractor.sv
src/hrde_checker.sv
sim/hrde_checker.sv
sim/tb_top.sv
